// ===== hdl/sdspi_pkg.sv =====
// Package for the SD-card SPI host sequencer: item structs, operation and
// phase codes, configuration indexes and the default block size. No dependencies.
package sdspi_pkg;

    localparam int BLOCK_BYTES_DEF = 512;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_XCHG  = 2'd3;

    localparam logic [2:0] CFG_POLL    = 3'd0;
    localparam logic [2:0] CFG_IDLE    = 3'd1;
    localparam logic [2:0] CFG_HC      = 3'd2;
    localparam logic [2:0] CFG_INIT    = 3'd3;
    localparam logic [2:0] CFG_BLKLEN  = 3'd4;
    localparam logic [2:0] CFG_PROTECT = 3'd5;

    typedef enum logic [5:0] {
        PH_IDLE = 6'd0, PH_CMD0 = 6'd1, PH_CMD8 = 6'd2, PH_V2_55 = 6'd3,
        PH_V2_41 = 6'd4, PH_CMD58 = 6'd5, PH_V1_55 = 6'd6, PH_V1_41 = 6'd7,
        PH_CMD1 = 6'd8, PH_CMD16 = 6'd9, PH_CMD17 = 6'd10, PH_CMD24 = 6'd11,
        PH_WAKE = 6'd20, PH_R7 = 6'd21, PH_R7_TAIL = 6'd22, PH_V1_GAP = 6'd23,
        PH_OCR = 6'd24, PH_OCR_TAIL = 6'd25, PH_DUMMY = 6'd26, PH_TOKEN = 6'd27,
        PH_RDATA = 6'd28, PH_RCRC = 6'd29, PH_RTAIL = 6'd30, PH_WPRE = 6'd31,
        PH_WTOKEN = 6'd32, PH_WDATA = 6'd33, PH_WCRC = 6'd34, PH_WRESP = 6'd35,
        PH_WBUSY = 6'd36
    } t_phase;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] sector;
        logic [7:0]  rx_byte;
        logic [7:0]  write_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       write_request;
        logic       done_res;
        logic [7:0] result_byte;
        logic [1:0] card_type;
        logic       busy_res;
    } t_out_item;

    typedef struct packed {
        logic [7:0] poll_limit;
        logic [7:0] idle_limit;
        logic [7:0] hc_limit;
        logic [7:0] init_limit;
        logic [7:0] blklen_limit;
        logic       protect;
    } t_cfg;

endpackage

// ===== hdl/sdspi_cfg_regs.sv =====
// Configuration register file of the SD-card SPI host sequencer.
// Depends on sdspi_pkg.
module sdspi_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output sdspi_pkg::t_cfg    o_cfg
);
    sdspi_pkg::t_cfg r_cfg;

    // Registers reset to their documented defaults and take one write a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_limit   <= 8'd10;
            r_cfg.idle_limit   <= 8'd10;
            r_cfg.hc_limit     <= 8'd50;
            r_cfg.init_limit   <= 8'd100;
            r_cfg.blklen_limit <= 8'd20;
            r_cfg.protect      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdspi_pkg::CFG_POLL:    r_cfg.poll_limit   <= i_cfg_data;
                sdspi_pkg::CFG_IDLE:    r_cfg.idle_limit   <= i_cfg_data;
                sdspi_pkg::CFG_HC:      r_cfg.hc_limit     <= i_cfg_data;
                sdspi_pkg::CFG_INIT:    r_cfg.init_limit   <= i_cfg_data;
                sdspi_pkg::CFG_BLKLEN:  r_cfg.blklen_limit <= i_cfg_data;
                sdspi_pkg::CFG_PROTECT: r_cfg.protect      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hdl/sdspi_core.sv =====
// Per-item sequencer step of the SD-card SPI host: state registers and
// the next-state and result logic. Depends on sdspi_pkg.
module sdspi_core #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  sdspi_pkg::t_in_item   i_item,
    input  sdspi_pkg::t_cfg       i_cfg,
    output sdspi_pkg::t_out_item  o_item
);
    sdspi_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_fpos, n_fpos;
    logic [9:0]  r_bcnt, n_bcnt;
    logic [7:0]  r_retry, n_retry;
    logic [7:0]  r_poll, n_poll;
    logic [5:0]  r_cidx, n_cidx;
    logic [31:0] r_carg, n_carg;
    logic [1:0]  r_ctype, n_ctype;
    logic [31:0] r_resp, n_resp;
    logic [7:0]  r_last, n_last;
    logic        r_sel, n_sel;
    sdspi_pkg::t_out_item o;

    logic [7:0]  rx;
    logic [31:0] addr;
    logic [7:0]  a;
    logic [7:0]  fb;
    logic [2:0]  fnext;
    logic [7:0]  poll_inc;
    logic [7:0]  retry_inc;
    logic [9:0]  bcnt_inc;
    logic        go_after;

    assign rx        = i_item.rx_byte;
    assign addr      = (r_ctype != 2'd3) ? {i_item.sector[22:0], 9'd0} : i_item.sector;
    assign fnext     = r_fpos + 3'd1;
    assign poll_inc  = r_poll + 8'd1;
    assign retry_inc = r_retry + 8'd1;
    assign bcnt_inc  = r_bcnt + 10'd1;

    // Next frame byte: argument bytes MSB first, then the CRC byte.
    always_comb begin
        case (fnext)
            3'd1: fb = r_carg[31:24];
            3'd2: fb = r_carg[23:16];
            3'd3: fb = r_carg[15:8];
            3'd4: fb = r_carg[7:0];
            default: fb = (r_cidx == 6'd0) ? 8'h95 : (r_cidx == 6'd8) ? 8'h87 : 8'h01;
        endcase
    end

    // Next state and result for one item.
    always_comb begin
        n_phase = r_phase; n_fpos = r_fpos; n_bcnt = r_bcnt; n_retry = r_retry;
        n_poll = r_poll; n_cidx = r_cidx; n_carg = r_carg; n_ctype = r_ctype;
        n_resp = r_resp; n_last = r_last; n_sel = r_sel;
        o = '0;
        o.chip_select = r_sel;
        a = rx;
        go_after = 1'b0;

        case (i_item.operation)
            sdspi_pkg::OP_INIT: begin
                n_ctype = 2'd0; n_retry = '0; n_bcnt = '0;
                n_phase = sdspi_pkg::PH_WAKE;
                o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b0; n_sel = 1'b0;
            end
            sdspi_pkg::OP_READ: begin
                n_phase = sdspi_pkg::PH_CMD17; n_cidx = 6'd17; n_carg = addr;
                n_fpos = '0; n_poll = '0;
                o.tx_byte = 8'h51; o.tx_valid = 1'b1; o.chip_select = 1'b1; n_sel = 1'b1;
            end
            sdspi_pkg::OP_WRITE: begin
                if (i_cfg.protect && i_item.sector == 32'd0) begin
                    o.done_res = 1'b1; o.result_byte = 8'hff;
                    n_phase = sdspi_pkg::PH_IDLE;
                end else begin
                    n_phase = sdspi_pkg::PH_CMD24; n_cidx = 6'd24; n_carg = addr;
                    n_fpos = '0; n_poll = '0;
                    o.tx_byte = 8'h58; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                    n_sel = 1'b1;
                end
            end
            default: begin
                // Command frame phases.
                if (r_phase >= sdspi_pkg::PH_CMD0 && r_phase <= sdspi_pkg::PH_CMD24) begin
                    if (r_fpos < 3'd5) begin
                        n_fpos = fnext;
                        o.tx_byte = fb; o.tx_valid = 1'b1; o.chip_select = 1'b1; n_sel = 1'b1;
                    end else if (r_fpos == 3'd5) begin
                        n_fpos = 3'd6; n_poll = '0;
                        o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                        n_sel = 1'b1;
                    end else if (r_fpos == 3'd6) begin
                        n_poll = poll_inc;
                        if (rx == 8'hff && poll_inc < i_cfg.poll_limit) begin
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                            n_sel = 1'b1;
                        end else begin
                            n_last = rx;
                            if (r_cidx == 6'd8 || r_cidx == 6'd58) begin
                                go_after = 1'b1; a = rx;
                            end else begin
                                n_fpos = 3'd7;
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b0; n_sel = 1'b0;
                            end
                        end
                    end else begin
                        go_after = 1'b1; a = r_last;
                    end
                end else begin
                    case (r_phase)
                        sdspi_pkg::PH_WAKE: begin
                            n_bcnt = bcnt_inc;
                            if (bcnt_inc < 10'd10) begin
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b0; n_sel = 1'b0;
                            end else if (bcnt_inc < 10'd12) begin
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                n_phase = sdspi_pkg::PH_CMD0; n_cidx = 6'd0; n_carg = '0;
                                n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h40; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end
                        end
                        sdspi_pkg::PH_R7, sdspi_pkg::PH_OCR: begin
                            n_resp = {r_resp[23:0], rx};
                            n_bcnt = bcnt_inc;
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                            if (bcnt_inc < 10'd4) begin
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                n_phase = (r_phase == sdspi_pkg::PH_R7) ?
                                    sdspi_pkg::PH_R7_TAIL : sdspi_pkg::PH_OCR_TAIL;
                                o.chip_select = 1'b0; n_sel = 1'b0;
                            end
                        end
                        sdspi_pkg::PH_R7_TAIL: begin
                            o.tx_valid = 1'b1;
                            if (r_resp[15:0] == 16'h01aa) begin
                                n_retry = '0; n_phase = sdspi_pkg::PH_V2_55; n_cidx = 6'd55;
                                n_carg = '0; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h77; o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                n_phase = sdspi_pkg::PH_DUMMY;
                                o.tx_byte = 8'hff; o.chip_select = 1'b0; n_sel = 1'b0;
                            end
                        end
                        sdspi_pkg::PH_V1_GAP: begin
                            n_retry = '0; n_phase = sdspi_pkg::PH_V1_55; n_cidx = 6'd55;
                            n_carg = '0; n_fpos = '0; n_poll = '0;
                            o.tx_byte = 8'h77; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                            n_sel = 1'b1;
                        end
                        sdspi_pkg::PH_OCR_TAIL: begin
                            n_ctype = r_resp[30] ? 2'd3 : 2'd2;
                            n_phase = sdspi_pkg::PH_DUMMY;
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b0;
                            n_sel = 1'b0;
                        end
                        sdspi_pkg::PH_DUMMY: begin
                            if (r_ctype != 2'd3) begin
                                n_retry = '0; n_phase = sdspi_pkg::PH_CMD16; n_cidx = 6'd16;
                                n_carg = 32'h200; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h50; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                o.done_res = 1'b1; o.result_byte = r_last;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end
                        end
                        sdspi_pkg::PH_TOKEN: begin
                            if (rx == 8'hfe) begin
                                n_phase = sdspi_pkg::PH_RDATA; n_bcnt = '0;
                            end
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                            n_sel = 1'b1;
                        end
                        sdspi_pkg::PH_RDATA: begin
                            o.data_byte = rx; o.data_valid = 1'b1;
                            n_bcnt = bcnt_inc;
                            if (bcnt_inc >= 10'(BLOCK_BYTES)) begin
                                n_phase = sdspi_pkg::PH_RCRC; n_bcnt = '0;
                            end
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                            n_sel = 1'b1;
                        end
                        sdspi_pkg::PH_RCRC: begin
                            n_bcnt = bcnt_inc;
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                            if (bcnt_inc < 10'd2) begin
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                n_phase = sdspi_pkg::PH_RTAIL;
                                o.chip_select = 1'b0; n_sel = 1'b0;
                            end
                        end
                        sdspi_pkg::PH_RTAIL: begin
                            o.done_res = 1'b1; n_phase = sdspi_pkg::PH_IDLE;
                        end
                        sdspi_pkg::PH_WPRE: begin
                            n_bcnt = bcnt_inc;
                            o.tx_valid = 1'b1; o.chip_select = 1'b1; n_sel = 1'b1;
                            if (bcnt_inc < 10'd3) begin
                                o.tx_byte = 8'hff;
                            end else begin
                                n_phase = sdspi_pkg::PH_WTOKEN;
                                o.tx_byte = 8'hfe; o.write_request = 1'b1;
                            end
                        end
                        sdspi_pkg::PH_WTOKEN: begin
                            n_bcnt = '0; n_phase = sdspi_pkg::PH_WDATA;
                            o.tx_byte = i_item.write_byte; o.tx_valid = 1'b1;
                            o.chip_select = 1'b1; n_sel = 1'b1;
                            o.write_request = (BLOCK_BYTES > 1);
                        end
                        sdspi_pkg::PH_WDATA: begin
                            n_bcnt = bcnt_inc;
                            o.tx_valid = 1'b1; o.chip_select = 1'b1; n_sel = 1'b1;
                            if (bcnt_inc < 10'(BLOCK_BYTES)) begin
                                o.tx_byte = i_item.write_byte;
                                o.write_request = ({1'b0, bcnt_inc} + 11'd1) < 11'(BLOCK_BYTES);
                            end else begin
                                n_bcnt = '0; n_phase = sdspi_pkg::PH_WCRC;
                                o.tx_byte = 8'hff;
                            end
                        end
                        sdspi_pkg::PH_WCRC: begin
                            n_bcnt = bcnt_inc;
                            if (bcnt_inc >= 10'd2) n_phase = sdspi_pkg::PH_WRESP;
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                            n_sel = 1'b1;
                        end
                        sdspi_pkg::PH_WRESP: begin
                            if (rx[4:0] != 5'h05) begin
                                o.done_res = 1'b1; o.result_byte = rx;
                                o.chip_select = 1'b0; n_sel = 1'b0;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_phase = sdspi_pkg::PH_WBUSY;
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end
                        end
                        sdspi_pkg::PH_WBUSY: begin
                            if (rx == 8'd0) begin
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                o.done_res = 1'b1; o.chip_select = 1'b0; n_sel = 1'b0;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end
                        end
                        default: n_phase = sdspi_pkg::PH_IDLE;
                    endcase
                end

                // Decision once a command response is in hand.
                if (go_after) begin
                    case (r_phase)
                        sdspi_pkg::PH_CMD0: begin
                            if (r_retry >= i_cfg.idle_limit) begin
                                o.done_res = 1'b1; o.result_byte = 8'd1;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_retry = retry_inc;
                                n_fpos = '0; n_poll = '0;
                                o.tx_valid = 1'b1; o.chip_select = 1'b1; n_sel = 1'b1;
                                if (a == 8'd1) begin
                                    n_phase = sdspi_pkg::PH_CMD8; n_cidx = 6'd8;
                                    n_carg = 32'h1aa; o.tx_byte = 8'h48;
                                end else begin
                                    n_phase = sdspi_pkg::PH_CMD0; n_cidx = 6'd0;
                                    n_carg = '0; o.tx_byte = 8'h40;
                                end
                            end
                        end
                        sdspi_pkg::PH_CMD8: begin
                            o.tx_byte = 8'hff; o.tx_valid = 1'b1; o.chip_select = 1'b1;
                            n_sel = 1'b1;
                            if (a == 8'd1) begin
                                n_phase = sdspi_pkg::PH_R7; n_bcnt = '0; n_resp = '0;
                            end else if (a == 8'd5) begin
                                n_phase = sdspi_pkg::PH_V1_GAP;
                            end else begin
                                n_phase = sdspi_pkg::PH_DUMMY;
                            end
                        end
                        sdspi_pkg::PH_V2_55: begin
                            if (a != 8'd1) begin
                                o.done_res = 1'b1; o.result_byte = a;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_phase = sdspi_pkg::PH_V2_41; n_cidx = 6'd41;
                                n_carg = 32'h4000_0000; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h69; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end
                        end
                        sdspi_pkg::PH_V2_41: begin
                            if (r_retry >= i_cfg.hc_limit) begin
                                o.done_res = 1'b1; o.result_byte = a;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_retry = retry_inc; n_carg = '0; n_fpos = '0; n_poll = '0;
                                o.tx_valid = 1'b1; o.chip_select = 1'b1; n_sel = 1'b1;
                                if (a != 8'd0) begin
                                    n_phase = sdspi_pkg::PH_V2_55; n_cidx = 6'd55;
                                    o.tx_byte = 8'h77;
                                end else begin
                                    n_phase = sdspi_pkg::PH_CMD58; n_cidx = 6'd58;
                                    o.tx_byte = 8'h7a;
                                end
                            end
                        end
                        sdspi_pkg::PH_CMD58: begin
                            if (a != 8'd0) begin
                                o.done_res = 1'b1; o.result_byte = a;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_phase = sdspi_pkg::PH_OCR; n_bcnt = '0; n_resp = '0;
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end
                        end
                        sdspi_pkg::PH_V1_55: begin
                            if (a != 8'd1) begin
                                o.done_res = 1'b1; o.result_byte = a;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_phase = sdspi_pkg::PH_V1_41; n_cidx = 6'd41;
                                n_carg = '0; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h69; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end
                        end
                        sdspi_pkg::PH_V1_41: begin
                            n_retry = retry_inc;
                            o.tx_valid = 1'b1;
                            if (a != 8'd0 && retry_inc < i_cfg.init_limit) begin
                                n_phase = sdspi_pkg::PH_V1_55; n_cidx = 6'd55;
                                n_carg = '0; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h77; o.chip_select = 1'b1; n_sel = 1'b1;
                            end else if (retry_inc >= i_cfg.init_limit) begin
                                n_retry = '0; n_phase = sdspi_pkg::PH_CMD1; n_cidx = 6'd1;
                                n_carg = '0; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h41; o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                n_ctype = 2'd1; n_phase = sdspi_pkg::PH_DUMMY;
                                o.tx_byte = 8'hff; o.chip_select = 1'b0; n_sel = 1'b0;
                            end
                        end
                        sdspi_pkg::PH_CMD1: begin
                            n_retry = retry_inc;
                            if (a != 8'd0 && retry_inc < i_cfg.init_limit) begin
                                n_phase = sdspi_pkg::PH_CMD1; n_cidx = 6'd1;
                                n_carg = '0; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h41; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end else if (retry_inc >= i_cfg.init_limit) begin
                                o.done_res = 1'b1; o.result_byte = 8'd1;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_ctype = 2'd0; n_phase = sdspi_pkg::PH_DUMMY;
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b0; n_sel = 1'b0;
                            end
                        end
                        sdspi_pkg::PH_CMD16: begin
                            n_retry = retry_inc;
                            if (a != 8'd0 && retry_inc < i_cfg.blklen_limit) begin
                                n_phase = sdspi_pkg::PH_CMD16; n_cidx = 6'd16;
                                n_carg = 32'h200; n_fpos = '0; n_poll = '0;
                                o.tx_byte = 8'h50; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end else begin
                                o.done_res = 1'b1; o.result_byte = a;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end
                        end
                        sdspi_pkg::PH_CMD17: begin
                            if (a != 8'd0) begin
                                o.done_res = 1'b1; o.result_byte = a;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_phase = sdspi_pkg::PH_TOKEN;
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end
                        end
                        default: begin
                            if (a != 8'd0) begin
                                o.done_res = 1'b1; o.result_byte = a;
                                n_phase = sdspi_pkg::PH_IDLE;
                            end else begin
                                n_phase = sdspi_pkg::PH_WPRE; n_bcnt = '0;
                                o.tx_byte = 8'hff; o.tx_valid = 1'b1;
                                o.chip_select = 1'b1; n_sel = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
        o.busy_res  = o.tx_valid;
        o.card_type = n_ctype;
    end

    // State update on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdspi_pkg::PH_IDLE;
            r_fpos <= '0; r_bcnt <= '0; r_retry <= '0; r_poll <= '0;
            r_cidx <= '0; r_carg <= '0; r_ctype <= '0; r_resp <= '0;
            r_last <= '0; r_sel <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_fpos <= n_fpos; r_bcnt <= n_bcnt; r_retry <= n_retry; r_poll <= n_poll;
            r_cidx <= n_cidx; r_carg <= n_carg; r_ctype <= n_ctype; r_resp <= n_resp;
            r_last <= n_last; r_sel <= n_sel;
        end
    end

    assign o_item = o;
endmodule

// ===== hdl/sd_card_spi_host_sequencer.sv =====
// Top level of the SD-card SPI host sequencer: input register, step logic
// and result register. Depends on sdspi_pkg, sdspi_cfg_regs and sdspi_core.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------
//  input    | i_in_valid / o_in_stall    | i_in_item
//  result   | o_out_valid / i_out_stall  | o_out_item
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Each item passes the input register, then the result register; one item
// a cycle is sustained while the result is not stalled. The item register
// is taken whenever it is empty or moves on to the result register in the
// same cycle. Reset is synchronous and empties both registers and returns
// to idle. A stalled result holds and back-pressures the input register.
module sd_card_spi_host_sequencer #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sdspi_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sdspi_pkg::t_out_item  o_out_item,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    sdspi_pkg::t_cfg      cfg;
    sdspi_pkg::t_in_item  r_item;
    logic                 r_item_v;
    sdspi_pkg::t_out_item r_res, step_res;
    logic                 r_res_v;
    logic                 res_free, step, in_take;

    assign res_free   = !r_res_v || !i_out_stall;
    assign step       = r_item_v && res_free;
    assign o_in_stall = r_item_v && !res_free;
    assign in_take    = i_in_valid && !o_in_stall;

    sdspi_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cfg(cfg)
    );

    sdspi_core #(.BLOCK_BYTES(BLOCK_BYTES)) u_core (
        .i_clk, .i_rst_n, .i_step(step), .i_item(r_item), .i_cfg(cfg),
        .o_item(step_res)
    );

    // Input item register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_v <= 1'b0;
        end else if (in_take) begin
            r_item_v <= 1'b1;
        end else if (step) begin
            r_item_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_item <= i_in_item;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (res_free) begin
            r_res_v <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_res <= step_res;
    end

    assign o_out_valid = r_res_v;
    assign o_out_item  = r_res;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the SD-card SPI host sequencer: a card model
// shapes the stimulus, a predictor works out each result. Needs sdspi_pkg and sd_card_spi_host_sequencer.
`timescale 1ns / 100ps

module testbench;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_stall;
    sdspi_pkg::t_in_item  in_item;
    logic                 out_valid;
    logic                 out_stall;
    sdspi_pkg::t_out_item out_item;
    logic                 cfg_we;
    logic [2:0]           cfg_index;
    logic [7:0]           cfg_data;

    sd_card_spi_host_sequencer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Items waiting to be sent and results still owed by the block.
    sdspi_pkg::t_in_item  pending_items[$];
    sdspi_pkg::t_out_item owed_results[$];
    int        offer_cnt;
    int        accept_cnt;
    int        result_cnt;
    int        done_cnt;
    int        mismatch_cnt;
    int        hold_left;
    bit        hold_used;

    // Predictor copy of the configuration and of the sequencer state.
    logic [7:0]  lim_poll, lim_idle, lim_hc, lim_init, lim_blklen;
    logic        prot_zero;
    sdspi_pkg::t_phase seq_ph;
    logic [2:0]  frame_pos;
    int          byte_cnt;
    logic [7:0]  retry_cnt, poll_cnt, cmd_idx, last_r1;
    logic [31:0] cmd_arg, resp_word;
    logic [1:0]  card_kind;
    logic        sel_line;
    sdspi_pkg::t_out_item nx;
    logic        last_busy;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Prediction of one step.
    task automatic emit(input logic [7:0] tx, input logic cs);
        nx.tx_byte = tx; nx.tx_valid = 1'b1; nx.busy_res = 1'b1;
        nx.chip_select = cs; sel_line = cs;
    endtask

    task automatic end_seq(input logic [7:0] r, input logic cs);
        nx.done_res = 1'b1; nx.result_byte = r; nx.chip_select = cs;
        sel_line = cs; seq_ph = sdspi_pkg::PH_IDLE;
    endtask

    task automatic start_cmd(input sdspi_pkg::t_phase p, input logic [7:0] idx,
                             input logic [31:0] arg);
        seq_ph = p; cmd_idx = idx & 8'h3f; cmd_arg = arg; frame_pos = 0; poll_cnt = 0;
        emit(8'h40 | cmd_idx, 1'b1);
    endtask

    function automatic logic [7:0] frame_byte(input logic [2:0] pos);
        if (pos >= 1 && pos <= 4) return 8'(cmd_arg >> (8 * (4 - pos)));
        if (cmd_idx == 0) return 8'h95;
        if (cmd_idx == 8) return 8'h87;
        return 8'h01;
    endfunction

    task automatic dummy_byte(input logic cs);
        seq_ph = sdspi_pkg::PH_DUMMY;
        emit(8'hff, cs);
    endtask

    task automatic after_cmd(input logic [7:0] a);
        case (seq_ph)
            sdspi_pkg::PH_CMD0: begin
                if (retry_cnt >= lim_idle) end_seq(8'd1, sel_line);
                else begin
                    retry_cnt++;
                    if (a == 1) start_cmd(sdspi_pkg::PH_CMD8, 8, 32'h1aa);
                    else start_cmd(sdspi_pkg::PH_CMD0, 0, 0);
                end
            end
            sdspi_pkg::PH_CMD8: begin
                if (a == 1) begin
                    seq_ph = sdspi_pkg::PH_R7; byte_cnt = 0; resp_word = 0;
                    emit(8'hff, 1'b1);
                end else if (a == 5) begin
                    seq_ph = sdspi_pkg::PH_V1_GAP; emit(8'hff, 1'b1);
                end else dummy_byte(1'b1);
            end
            sdspi_pkg::PH_V2_55: begin
                if (a != 1) end_seq(a, sel_line);
                else start_cmd(sdspi_pkg::PH_V2_41, 41, 32'h4000_0000);
            end
            sdspi_pkg::PH_V2_41: begin
                if (retry_cnt >= lim_hc) end_seq(a, sel_line);
                else begin
                    retry_cnt++;
                    if (a != 0) start_cmd(sdspi_pkg::PH_V2_55, 55, 0);
                    else start_cmd(sdspi_pkg::PH_CMD58, 58, 0);
                end
            end
            sdspi_pkg::PH_CMD58: begin
                if (a != 0) end_seq(a, sel_line);
                else begin
                    seq_ph = sdspi_pkg::PH_OCR; byte_cnt = 0; resp_word = 0;
                    emit(8'hff, 1'b1);
                end
            end
            sdspi_pkg::PH_V1_55: begin
                if (a != 1) end_seq(a, sel_line);
                else start_cmd(sdspi_pkg::PH_V1_41, 41, 0);
            end
            sdspi_pkg::PH_V1_41: begin
                retry_cnt++;
                if (a != 0 && retry_cnt < lim_init) start_cmd(sdspi_pkg::PH_V1_55, 55, 0);
                else if (retry_cnt >= lim_init) begin
                    retry_cnt = 0; start_cmd(sdspi_pkg::PH_CMD1, 1, 0);
                end else begin
                    card_kind = 2'd1; dummy_byte(1'b0);
                end
            end
            sdspi_pkg::PH_CMD1: begin
                retry_cnt++;
                if (a != 0 && retry_cnt < lim_init) start_cmd(sdspi_pkg::PH_CMD1, 1, 0);
                else if (retry_cnt >= lim_init) end_seq(8'd1, sel_line);
                else begin
                    card_kind = 2'd0; dummy_byte(1'b0);
                end
            end
            sdspi_pkg::PH_CMD16: begin
                retry_cnt++;
                if (a != 0 && retry_cnt < lim_blklen)
                    start_cmd(sdspi_pkg::PH_CMD16, 16, 32'h200);
                else end_seq(a, sel_line);
            end
            sdspi_pkg::PH_CMD17: begin
                if (a != 0) end_seq(a, sel_line);
                else begin
                    seq_ph = sdspi_pkg::PH_TOKEN; emit(8'hff, 1'b1);
                end
            end
            default: begin
                if (a != 0) end_seq(a, sel_line);
                else begin
                    seq_ph = sdspi_pkg::PH_WPRE; byte_cnt = 0; emit(8'hff, 1'b1);
                end
            end
        endcase
    endtask

    task automatic cmd_exchange(input logic [7:0] rx);
        if (frame_pos < 5) begin
            frame_pos++;
            emit(frame_byte(frame_pos), 1'b1);
        end else if (frame_pos == 5) begin
            frame_pos = 6; poll_cnt = 0; emit(8'hff, 1'b1);
        end else if (frame_pos == 6) begin
            poll_cnt++;
            if (rx == 8'hff && poll_cnt < lim_poll) emit(8'hff, 1'b1);
            else begin
                last_r1 = rx;
                if (cmd_idx == 8 || cmd_idx == 58) after_cmd(rx);
                else begin
                    frame_pos = 7; emit(8'hff, 1'b0);
                end
            end
        end else after_cmd(last_r1);
    endtask

    task automatic byte_exchange(input logic [7:0] rx, input logic [7:0] wb);
        if (seq_ph >= sdspi_pkg::PH_CMD0 && seq_ph <= sdspi_pkg::PH_CMD24) begin
            cmd_exchange(rx);
            return;
        end
        case (seq_ph)
            sdspi_pkg::PH_WAKE: begin
                byte_cnt++;
                if (byte_cnt < 10) emit(8'hff, 1'b0);
                else if (byte_cnt < 12) emit(8'hff, 1'b1);
                else start_cmd(sdspi_pkg::PH_CMD0, 0, 0);
            end
            sdspi_pkg::PH_R7, sdspi_pkg::PH_OCR: begin
                resp_word = (resp_word << 8) | rx;
                byte_cnt++;
                if (byte_cnt < 4) emit(8'hff, 1'b1);
                else begin
                    seq_ph = (seq_ph == sdspi_pkg::PH_R7) ?
                        sdspi_pkg::PH_R7_TAIL : sdspi_pkg::PH_OCR_TAIL;
                    emit(8'hff, 1'b0);
                end
            end
            sdspi_pkg::PH_R7_TAIL: begin
                if (resp_word[15:0] == 16'h01aa) begin
                    retry_cnt = 0; start_cmd(sdspi_pkg::PH_V2_55, 55, 0);
                end else dummy_byte(1'b0);
            end
            sdspi_pkg::PH_V1_GAP: begin
                retry_cnt = 0; start_cmd(sdspi_pkg::PH_V1_55, 55, 0);
            end
            sdspi_pkg::PH_OCR_TAIL: begin
                card_kind = resp_word[30] ? 2'd3 : 2'd2;
                dummy_byte(1'b0);
            end
            sdspi_pkg::PH_DUMMY: begin
                if (card_kind != 3) begin
                    retry_cnt = 0; start_cmd(sdspi_pkg::PH_CMD16, 16, 32'h200);
                end else end_seq(last_r1, sel_line);
            end
            sdspi_pkg::PH_TOKEN: begin
                if (rx == 8'hfe) begin
                    seq_ph = sdspi_pkg::PH_RDATA; byte_cnt = 0;
                end
                emit(8'hff, 1'b1);
            end
            sdspi_pkg::PH_RDATA: begin
                nx.data_byte = rx; nx.data_valid = 1'b1;
                byte_cnt++;
                if (byte_cnt >= sdspi_pkg::BLOCK_BYTES_DEF) begin
                    seq_ph = sdspi_pkg::PH_RCRC; byte_cnt = 0;
                end
                emit(8'hff, 1'b1);
            end
            sdspi_pkg::PH_RCRC: begin
                byte_cnt++;
                if (byte_cnt < 2) emit(8'hff, 1'b1);
                else begin
                    seq_ph = sdspi_pkg::PH_RTAIL; emit(8'hff, 1'b0);
                end
            end
            sdspi_pkg::PH_RTAIL: end_seq(8'd0, sel_line);
            sdspi_pkg::PH_WPRE: begin
                byte_cnt++;
                if (byte_cnt < 3) emit(8'hff, 1'b1);
                else begin
                    seq_ph = sdspi_pkg::PH_WTOKEN; emit(8'hfe, 1'b1);
                    nx.write_request = 1'b1;
                end
            end
            sdspi_pkg::PH_WTOKEN: begin
                byte_cnt = 0; seq_ph = sdspi_pkg::PH_WDATA;
                emit(wb, 1'b1); nx.write_request = 1'b1;
            end
            sdspi_pkg::PH_WDATA: begin
                byte_cnt++;
                if (byte_cnt < sdspi_pkg::BLOCK_BYTES_DEF) begin
                    emit(wb, 1'b1);
                    nx.write_request = (byte_cnt + 1 < sdspi_pkg::BLOCK_BYTES_DEF);
                end else begin
                    byte_cnt = 0; seq_ph = sdspi_pkg::PH_WCRC; emit(8'hff, 1'b1);
                end
            end
            sdspi_pkg::PH_WCRC: begin
                byte_cnt++;
                if (byte_cnt >= 2) seq_ph = sdspi_pkg::PH_WRESP;
                emit(8'hff, 1'b1);
            end
            sdspi_pkg::PH_WRESP: begin
                if ((rx & 8'h1f) != 8'h05) end_seq(rx, 1'b0);
                else begin
                    seq_ph = sdspi_pkg::PH_WBUSY; emit(8'hff, 1'b1);
                end
            end
            sdspi_pkg::PH_WBUSY: begin
                if (rx == 0) emit(8'hff, 1'b1);
                else end_seq(8'd0, 1'b0);
            end
            default: seq_ph = sdspi_pkg::PH_IDLE;
        endcase
    endtask

    task automatic predict_result(input sdspi_pkg::t_in_item it,
                                  output sdspi_pkg::t_out_item res);
        logic [31:0] addr;
        nx = '0;
        nx.chip_select = sel_line;
        addr = (card_kind != 3) ? (it.sector << 9) : it.sector;
        case (it.operation)
            sdspi_pkg::OP_INIT: begin
                card_kind = 0; retry_cnt = 0; byte_cnt = 0; seq_ph = sdspi_pkg::PH_WAKE;
                emit(8'hff, 1'b0);
            end
            sdspi_pkg::OP_READ: start_cmd(sdspi_pkg::PH_CMD17, 17, addr);
            sdspi_pkg::OP_WRITE: begin
                if (prot_zero && it.sector == 0) end_seq(8'hff, sel_line);
                else start_cmd(sdspi_pkg::PH_CMD24, 24, addr);
            end
            default: byte_exchange(it.rx_byte, it.write_byte);
        endcase
        byte_cnt &= 32'h3ff;
        nx.card_type = card_kind;
        res = nx;
    endtask

    // Card behaviour: mostly sensible answers for the current phase, some noise.
    function automatic logic [7:0] card_answer();
        int r;
        r = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 6) return 8'($urandom);
        if (seq_ph >= sdspi_pkg::PH_CMD0 && seq_ph <= sdspi_pkg::PH_CMD24) begin
            if (frame_pos != 6 || $urandom_range(0, 3) == 0) return 8'hff;
            case (seq_ph)
                sdspi_pkg::PH_CMD0:  return (r < 7) ? 8'h01 : 8'h00;
                sdspi_pkg::PH_CMD8:  return (r < 6) ? 8'h01 : ((r < 9) ? 8'h05 : 8'h7f);
                sdspi_pkg::PH_V2_55, sdspi_pkg::PH_V1_55: return (r < 9) ? 8'h01 : 8'h05;
                sdspi_pkg::PH_V2_41, sdspi_pkg::PH_V1_41, sdspi_pkg::PH_CMD1:
                    return (r < 5) ? 8'h01 : 8'h00;
                sdspi_pkg::PH_CMD58: return (r < 9) ? 8'h00 : 8'h01;
                sdspi_pkg::PH_CMD16: return (r < 7) ? 8'h00 : 8'h04;
                default:  return (r < 9) ? 8'h00 : 8'h04;
            endcase
        end
        case (seq_ph)
            sdspi_pkg::PH_R7: begin
                if (byte_cnt == 2) return (r < 9) ? 8'h01 : 8'h02;
                if (byte_cnt == 3) return (r < 9) ? 8'haa : 8'h55;
                return 8'($urandom);
            end
            sdspi_pkg::PH_OCR:
                return (byte_cnt == 0) ? ((r < 5) ? 8'hc0 : 8'h80) : 8'($urandom);
            sdspi_pkg::PH_TOKEN: return (r < 3) ? 8'hfe : 8'hff;
            sdspi_pkg::PH_WRESP: return (r < 8) ? {3'($urandom), 5'h05} : 8'($urandom);
            sdspi_pkg::PH_WBUSY: return (r < 6) ? 8'h00 : 8'($urandom_range(1, 255));
            default:  return 8'($urandom);
        endcase
    endfunction

    // Queue one item together with the result it causes.
    task automatic queue_item(input logic [1:0] op, input logic [31:0] sec,
                              input logic [7:0] rx, input logic [7:0] wb);
        sdspi_pkg::t_in_item  it;
        sdspi_pkg::t_out_item res;
        it.operation = op; it.sector = sec; it.rx_byte = rx; it.write_byte = wb;
        predict_result(it, res);
        last_busy = res.tx_valid;
        pending_items.push_back(it);
        owed_results.push_back(res);
    endtask

    function automatic logic [31:0] pick_sector();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 32'h0;
        if (r == 3) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Random traffic: mostly complete sequences, some aborted starts and stray bytes.
    task automatic queue_random(input int count);
        int n;
        int r;
        n = 0;
        while (n < count || last_busy) begin
            r = $urandom_range(0, 99);
            if (!last_busy || (r == 0 && n < count)) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    queue_item(sdspi_pkg::OP_XCHG, $urandom, 8'($urandom), 8'($urandom));
                else if (r < 60)
                    queue_item(sdspi_pkg::OP_INIT, $urandom, 8'($urandom), 8'($urandom));
                else if (r < 80)
                    queue_item(sdspi_pkg::OP_READ, pick_sector(), 8'($urandom),
                               8'($urandom));
                else
                    queue_item(sdspi_pkg::OP_WRITE, pick_sector(), 8'($urandom),
                               8'($urandom));
            end else queue_item(sdspi_pkg::OP_XCHG, $urandom, card_answer(), 8'($urandom));
            n++;
        end
    endtask

    // Let the block drain, then allow for its input and result registers.
    task automatic wait_drained();
        while (pending_items.size() != 0 || owed_results.size() != 0 || in_valid)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            sdspi_pkg::CFG_POLL:   lim_poll = val;
            sdspi_pkg::CFG_IDLE:   lim_idle = val;
            sdspi_pkg::CFG_HC:     lim_hc = val;
            sdspi_pkg::CFG_INIT:   lim_init = val;
            sdspi_pkg::CFG_BLKLEN: lim_blklen = val;
            default:    prot_zero = val[0];
        endcase
    endtask

    task automatic write_all(input logic [7:0] p, input logic [7:0] i, input logic [7:0] h,
                             input logic [7:0] n, input logic [7:0] b, input logic pr);
        wait_drained();
        write_reg(sdspi_pkg::CFG_POLL, p);
        write_reg(sdspi_pkg::CFG_IDLE, i);
        write_reg(sdspi_pkg::CFG_HC, h);
        write_reg(sdspi_pkg::CFG_INIT, n);
        write_reg(sdspi_pkg::CFG_BLKLEN, b);
        write_reg(sdspi_pkg::CFG_PROTECT, {7'd0, pr});
    endtask

    // Stimulus and phase control.
    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        lim_poll = 10; lim_idle = 10; lim_hc = 50; lim_init = 100; lim_blklen = 20;
        prot_zero = 1'b1;
        seq_ph = sdspi_pkg::PH_IDLE; frame_pos = 0; byte_cnt = 0; retry_cnt = 0;
        poll_cnt = 0;
        cmd_idx = 0; cmd_arg = 0; card_kind = 0; resp_word = 0; last_r1 = 0;
        sel_line = 1'b0; last_busy = 1'b0;
        mismatch_cnt = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: stray bytes while idle, protected sector zero, aborted starts.
        queue_item(sdspi_pkg::OP_XCHG, 32'h0, 8'h00, 8'h00);
        queue_item(sdspi_pkg::OP_XCHG, 32'hffff_ffff, 8'hff, 8'hff);
        queue_item(sdspi_pkg::OP_WRITE, 32'h0, 8'h00, 8'h00);
        queue_item(sdspi_pkg::OP_WRITE, 32'hffff_ffff, 8'hff, 8'hff);
        queue_item(sdspi_pkg::OP_READ, 32'hffff_ffff, 8'h00, 8'h00);
        queue_item(sdspi_pkg::OP_INIT, 32'h0, 8'h00, 8'h00);
        repeat (14) queue_item(sdspi_pkg::OP_XCHG, 32'h0, 8'hff, 8'h00);
        queue_random(460);

        // Lowest limits: late CMD0 success and last ACMD41 round cases.
        write_all(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 1'b0);
        queue_random(480);
        write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        queue_random(480);
        write_all(8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                  8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                  8'($urandom_range(1, 3)), 1'b0);
        queue_random(480);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("tb: %0d items checked, %0d sequences finished, four register settings",
                 result_cnt, done_cnt);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", mismatch_cnt);
            $display("tb: failure");
        end
        $finish;
    end

    // Input driver: offers the oldest pending item, idling now and then.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_item <= '0;
            offer_cnt <= 0;
        end else if (!in_valid || accept_cnt == offer_cnt) begin
            if (pending_items.size() != 0 &&
                ((accept_cnt > 700 && accept_cnt < 1000) || $urandom_range(0, 99) >= 17)) begin
                in_valid <= 1'b1;
                in_item <= pending_items[0];
                offer_cnt <= offer_cnt + 1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Acceptance of input items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            accept_cnt <= 0;
        end else if (in_valid && !in_stall) begin
            accept_cnt <= accept_cnt + 1;
            void'(pending_items.pop_front());
        end
    end

    // Result stall: random, one long hold-off, and a quiet window.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_used && result_cnt >= 300) begin
            out_stall <= 1'b1;
            hold_left <= 200;
            hold_used <= 1'b1;
        end else if (result_cnt > 1200 && result_cnt < 1500) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < 17);
        end
    end

    // Result monitor: compare each item with the oldest owed result.
    always @(posedge i_clk) begin
        sdspi_pkg::t_out_item want;
        if (!i_rst_n) begin
            result_cnt <= 0;
            done_cnt <= 0;
        end else if (out_valid && !out_stall) begin
            result_cnt <= result_cnt + 1;
            if (out_item.done_res) done_cnt <= done_cnt + 1;
            if (owed_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("tb: unexpected result %h", out_item);
            end else begin
                want = owed_results.pop_front();
                if (out_item !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display({"tb: result %0d: tx %h/%b cs %b data %h/%b wreq %b",
                                  " done %b res %h type %0d busy %b"},
                                 result_cnt, out_item.tx_byte, out_item.tx_valid,
                                 out_item.chip_select, out_item.data_byte,
                                 out_item.data_valid, out_item.write_request,
                                 out_item.done_res, out_item.result_byte,
                                 out_item.card_type, out_item.busy_res);
                        $display({"tb:   expected tx %h/%b cs %b data %h/%b wreq %b",
                                  " done %b res %h type %0d busy %b"},
                                 want.tx_byte, want.tx_valid, want.chip_select,
                                 want.data_byte, want.data_valid, want.write_request,
                                 want.done_res, want.result_byte, want.card_type,
                                 want.busy_res);
                    end
                end
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sdspi_pkg.sv
hdl/sdspi_cfg_regs.sv
hdl/sdspi_core.sv
hdl/sd_card_spi_host_sequencer.sv
tb/testbench.sv
